FILE: rtl/dske_pkg.sv
package dske_pkg;

  localparam int MLKEM_KEY_BYTES  = 1184;
  localparam int MLKEM_MIN_TOTAL  = 1206;
  localparam int X25519_KEY_BYTES = 32;
  localparam int X25519_MIN_TOTAL = 44;

  localparam int CNT_W     = 16;
  localparam int KEY_CNT_W = 11;
  localparam int TIDX_W    = 4;

  localparam logic [TIDX_W-1:0] TMPL_LEN_X25519 = TIDX_W'(7);
  localparam logic [TIDX_W-1:0] TMPL_LEN_MLKEM  = TIDX_W'(13);

  localparam logic [7:0] DER_TAG_SEQ    = 8'h30;
  localparam logic [7:0] DER_TAG_BITSTR = 8'h03;
  localparam logic [7:0] DER_LEN_LONG   = 8'h80;
  localparam logic [7:0] DER_LEN_LONG1  = 8'h81;
  localparam logic [7:0] DER_LEN_LONG2  = 8'h82;
  localparam logic [7:0] DER_PAD_ZERO   = 8'h00;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic KEY_TYPE_X25519 = 1'b0;
  localparam logic KEY_TYPE_MLKEM  = 1'b1;

  typedef enum logic [3:0] {
    PH_OUTER_TAG = 4'd0,
    PH_OUTER_LEN = 4'd1,
    PH_OUTER_EXT = 4'd2,
    PH_ALGID     = 4'd3,
    PH_BS_TAG    = 4'd4,
    PH_BS_LEN    = 4'd5,
    PH_BS_EXT    = 4'd6,
    PH_PAD       = 4'd7,
    PH_KEY       = 4'd8,
    PH_TRAIL     = 4'd9
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       key_valid;
    logic       done_res;
    logic       status;
  } out_item_t;

  // algorithm identifier templates
  function automatic logic [7:0] tmpl_byte(input logic mlkem, input logic [TIDX_W-1:0] idx);
    logic [7:0] res;
    res = 8'h00;
    if (mlkem) begin
      case (idx)
        4'd0:    res = 8'h30;
        4'd1:    res = 8'h0B;
        4'd2:    res = 8'h06;
        4'd3:    res = 8'h09;
        4'd4:    res = 8'h60;
        4'd5:    res = 8'h86;
        4'd6:    res = 8'h48;
        4'd7:    res = 8'h01;
        4'd8:    res = 8'h65;
        4'd9:    res = 8'h03;
        4'd10:   res = 8'h04;
        4'd11:   res = 8'h04;
        4'd12:   res = 8'h02;
        default: res = 8'h00;
      endcase
    end else begin
      case (idx)
        4'd0:    res = 8'h30;
        4'd1:    res = 8'h05;
        4'd2:    res = 8'h06;
        4'd3:    res = 8'h03;
        4'd4:    res = 8'h2B;
        4'd5:    res = 8'h65;
        4'd6:    res = 8'h6E;
        default: res = 8'h00;
      endcase
    end
    return res;
  endfunction

endpackage

FILE: rtl/der_spki_key_extractor.sv
// der_spki_key_extractor
// Streams a DER SubjectPublicKeyInfo one byte per transaction on the input
// channel (in_valid_i / in_stall_o / in_data_i) and returns the raw public key
// bytes on the output channel (out_valid_o / out_stall_i / out_data_o).
// A result is produced for every key byte and for the byte marked is_last;
// the last result carries done_res and status (0 success, 1 malformed).
// Header, trailing and error bytes produce no result unless marked last.
// cfg_we_i / cfg_wdata_i write key_type (0 X25519, 1 ML-KEM-768); write it
// only while no transaction is in flight.
// Throughput: one byte per cycle while the receiver does not stall. The
// accepting edge loads the input register, and the parsed result moves into
// the output register once that register is free.
// When the receiver stalls, the output register holds its result; the input
// register takes one more byte only if empty, and in_stall_o rises once it is full.
// Reset clears the valid bits of both pipeline registers, the parser state
// and key_type; the block accepts bytes as soon as reset is released.
module der_spki_key_extractor
  import dske_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic                 key_type_q;
  logic                 s1_valid_q;
  in_item_t             s1_data_q;
  logic                 out_valid_q;
  out_item_t            out_data_q;

  phase_e               phase_q, phase_d;
  logic [CNT_W-1:0]     len_acc_q, len_acc_d;
  logic [1:0]           len_left_q, len_left_d;
  logic [TIDX_W-1:0]    tmpl_idx_q, tmpl_idx_d;
  logic [CNT_W-1:0]     outer_len_q, outer_len_d;
  logic [CNT_W-1:0]     after_outer_q, after_outer_d;
  logic [CNT_W-1:0]     total_q, total_d;
  logic [KEY_CNT_W-1:0] key_cnt_q, key_cnt_d;
  logic                 err_q, err_d;

  logic                 out_free;
  logic                 s1_adv;
  logic                 accept_in;
  logic                 emit;
  out_item_t            res;

  logic                 mlkem;
  logic [KEY_CNT_W-1:0] kbytes;
  logic [CNT_W-1:0]     mintot;
  logic [CNT_W-1:0]     bs_len_exp;
  logic [TIDX_W-1:0]    tlen;
  logic [7:0]           b;
  logic                 last;

  logic [CNT_W-1:0]     lf_acc;
  logic [1:0]           lf_left;
  logic                 lf_fin;
  logic                 lf_err;
  logic [CNT_W-1:0]     le_acc;
  logic [1:0]           le_left;
  logic                 le_fin;
  logic                 kvalid;
  logic                 ok;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_adv      = s1_valid_q && out_free;
  assign in_stall_o  = s1_valid_q && !out_free;
  assign accept_in   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign mlkem      = (key_type_q == KEY_TYPE_MLKEM);
  assign kbytes     = mlkem ? KEY_CNT_W'(MLKEM_KEY_BYTES) : KEY_CNT_W'(X25519_KEY_BYTES);
  assign mintot     = mlkem ? CNT_W'(MLKEM_MIN_TOTAL) : CNT_W'(X25519_MIN_TOTAL);
  assign bs_len_exp = mlkem ? CNT_W'(MLKEM_KEY_BYTES + 1) : CNT_W'(X25519_KEY_BYTES + 1);
  assign tlen       = mlkem ? TMPL_LEN_MLKEM : TMPL_LEN_X25519;
  assign b          = s1_data_q.data_byte;
  assign last       = s1_data_q.is_last;

  // first length byte decode
  always_comb begin
    lf_acc  = '0;
    lf_left = len_left_q;
    lf_fin  = 1'b0;
    lf_err  = 1'b0;
    if (b < DER_LEN_LONG) begin
      lf_acc = {{(CNT_W-8){1'b0}}, b};
      lf_fin = 1'b1;
    end else if (b == DER_LEN_LONG1) begin
      lf_left = 2'd1;
    end else if (b == DER_LEN_LONG2) begin
      lf_left = 2'd2;
    end else begin
      lf_err = 1'b1;
    end
  end

  // extended length byte
  assign le_acc  = {len_acc_q[CNT_W-9:0], b};
  assign le_left = len_left_q - 2'd1;
  assign le_fin  = (le_left == 2'd0);

  always_comb begin
    phase_d       = phase_q;
    len_acc_d     = len_acc_q;
    len_left_d    = len_left_q;
    tmpl_idx_d    = tmpl_idx_q;
    outer_len_d   = outer_len_q;
    key_cnt_d     = key_cnt_q;
    err_d         = err_q;
    kvalid        = 1'b0;
    total_d       = (total_q != '1) ? total_q + CNT_W'(1) : total_q;
    after_outer_d = after_outer_q;
    if (phase_q >= PH_ALGID && after_outer_q != '1) begin
      after_outer_d = after_outer_q + CNT_W'(1);
    end
    if (!err_q) begin
      case (phase_q)
        PH_OUTER_TAG: begin
          if (b == DER_TAG_SEQ) phase_d = PH_OUTER_LEN;
          else err_d = 1'b1;
        end
        PH_OUTER_LEN, PH_OUTER_EXT: begin
          if (phase_q == PH_OUTER_LEN) begin
            len_acc_d  = lf_acc;
            len_left_d = lf_left;
            err_d      = lf_err;
          end else begin
            len_acc_d  = le_acc;
            len_left_d = le_left;
          end
          if (!err_d) begin
            if ((phase_q == PH_OUTER_LEN) ? lf_fin : le_fin) begin
              outer_len_d = len_acc_d;
              tmpl_idx_d  = '0;
              phase_d     = PH_ALGID;
            end else begin
              phase_d = PH_OUTER_EXT;
            end
          end
        end
        PH_ALGID: begin
          if (tmpl_idx_q >= tlen) begin
            err_d = 1'b1;
          end else if (b != tmpl_byte(mlkem, tmpl_idx_q)) begin
            err_d = 1'b1;
          end else begin
            tmpl_idx_d = tmpl_idx_q + TIDX_W'(1);
            if (tmpl_idx_d == tlen) phase_d = PH_BS_TAG;
          end
        end
        PH_BS_TAG: begin
          if (b == DER_TAG_BITSTR) phase_d = PH_BS_LEN;
          else err_d = 1'b1;
        end
        PH_BS_LEN, PH_BS_EXT: begin
          if (phase_q == PH_BS_LEN) begin
            len_acc_d  = lf_acc;
            len_left_d = lf_left;
            err_d      = lf_err;
          end else begin
            len_acc_d  = le_acc;
            len_left_d = le_left;
          end
          if (!err_d) begin
            if ((phase_q == PH_BS_LEN) ? lf_fin : le_fin) begin
              if (len_acc_d == bs_len_exp) phase_d = PH_PAD;
              else err_d = 1'b1;
            end else begin
              phase_d = PH_BS_EXT;
            end
          end
        end
        PH_PAD: begin
          if (b == DER_PAD_ZERO) begin
            key_cnt_d = '0;
            phase_d   = PH_KEY;
          end else begin
            err_d = 1'b1;
          end
        end
        PH_KEY: begin
          kvalid    = 1'b1;
          key_cnt_d = key_cnt_q + KEY_CNT_W'(1);
          if (key_cnt_d >= kbytes) phase_d = PH_TRAIL;
        end
        default: ;
      endcase
    end

    ok = !err_d && (phase_d == PH_TRAIL) && (total_d >= mintot) &&
         (outer_len_d <= after_outer_d);

    emit          = kvalid || last;
    res.key_byte  = kvalid ? b : 8'h00;
    res.key_valid = kvalid;
    res.done_res  = last;
    res.status    = (last && !ok) ? STATUS_ERR : STATUS_OK;

    // end of structure: back to the start
    if (last) begin
      phase_d       = PH_OUTER_TAG;
      len_acc_d     = '0;
      len_left_d    = '0;
      tmpl_idx_d    = '0;
      outer_len_d   = '0;
      after_outer_d = '0;
      total_d       = '0;
      key_cnt_d     = '0;
      err_d         = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_type_q    <= KEY_TYPE_X25519;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      phase_q       <= PH_OUTER_TAG;
      len_acc_q     <= '0;
      len_left_q    <= '0;
      tmpl_idx_q    <= '0;
      outer_len_q   <= '0;
      after_outer_q <= '0;
      total_q       <= '0;
      key_cnt_q     <= '0;
      err_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        key_type_q <= cfg_wdata_i;
      end
      if (accept_in) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q   <= emit;
        phase_q       <= phase_d;
        len_acc_q     <= len_acc_d;
        len_left_q    <= len_left_d;
        tmpl_idx_q    <= tmpl_idx_d;
        outer_len_q   <= outer_len_d;
        after_outer_q <= after_outer_d;
        total_q       <= total_d;
        key_cnt_q     <= key_cnt_d;
        err_q         <= err_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      s1_data_q <= in_data_i;
    end
    if (s1_adv) begin
      out_data_q <= res;
    end
  end

endmodule

FILE: rtl/dske_checker.sv
module dske_checker
  import dske_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // every result carries a key byte or the end of structure
  a_no_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.key_valid || out_data_o.done_res))
    else $error("empty result");

  a_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.key_valid |-> out_data_o.key_byte == 8'h00)
    else $error("key byte set without key_valid");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.done_res |-> out_data_o.status == STATUS_OK)
    else $error("status set without done");

  // an empty output register never blocks the input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind der_spki_key_extractor dske_checker u_dske_checker (.*);
